[hw/rtl/aftt_pkg.sv]
package aftt_pkg;

	localparam int unsigned TABLE_DEPTH_DEFAULT = 32;

	localparam logic [26:0] TIMEOUT_BASE_MS = 27'd30000;
	localparam logic [26:0] DAY_MS          = 27'(1000 * 60 * 60 * 24);

	localparam logic [1:0] CMD_CHECK = 2'd0;
	localparam logic [1:0] CMD_FAIL  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [63:0] user;
		logic [31:0] failures;
		logic [63:0] stamp;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVAL,
		ST_DECIDE
	} state_t;

	// retry timeout from a failure count
	function automatic logic [26:0] retry_timeout(input logic [31:0] c);
		logic [3:0]  sh;
		logic [26:0] to;
		sh = 4'd0;
		for (int j = 1; j <= 10; j++) begin
			if (c >= 32'(30 + 10 * j)) begin
				sh = 4'(j);
			end
		end
		if (c == 32'd0) begin
			to = 27'd0;
		end else if (c <= 32'd10) begin
			to = (c == 32'd5 || c == 32'd10) ? TIMEOUT_BASE_MS : 27'd0;
		end else if (c < 32'd30) begin
			to = TIMEOUT_BASE_MS;
		end else if (c < 32'd140) begin
			to = TIMEOUT_BASE_MS << sh;
		end else begin
			to = DAY_MS;
		end
		return to;
	endfunction

endpackage

[hw/rtl/aftt_ram.sv]
module aftt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/auth_failure_throttle_table.sv]
// Per-user authentication failure table. Each command (check, record failure, clear)
// is taken one at a time: the block reads every stored record through the single read
// port of its table memory, one per cycle, to find the user and the record with the
// oldest time, then works out the retry timeout and writes at most one record back.
// A command passes through the table scan, the evaluation and the decision before the
// next transfer is taken; the scan grows with the number of stored records. A result
// still waiting to be collected holds the write-back and so delays the next transfer.
// The result sits in an output register, so the next command is taken while it waits
// to be collected.
module auth_failure_throttle_table #(
	parameter int unsigned TABLE_DEPTH = aftt_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [63:0] user_id,
	input  logic [63:0] timestamp,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        throttled,
	output logic [26:0] wait_ms,
	output logic [31:0] failure_count,
	output logic [63:0] last_time
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	aftt_pkg::state_t state_q, state_d;

	logic [CW-1:0] used_q;
	logic [CW-1:0] idx_q;
	logic          rd_pend_s1;
	logic [AW-1:0] rd_idx_s1;

	logic [1:0]    cmd_q;
	logic [63:0]   uid_q;
	logic [63:0]   ts_q;
	logic          found_q;
	logic [AW-1:0] match_q;
	logic [31:0]   cnt_q;
	logic [63:0]   tm_q;
	logic [63:0]   old_tm_q;
	logic [AW-1:0] old_idx_q;

	logic [26:0]   to_q;
	logic          gt_q;
	logic [63:0]   diff_q;

	logic          out_valid_q;
	logic          thr_q;
	logic [26:0]   wait_q;
	logic [31:0]   cnt_out_q;
	logic [63:0]   tm_out_q;

	logic             accept;
	logic             rd_en;
	logic             finish;
	aftt_pkg::entry_t rd_data;
	aftt_pkg::entry_t wr_data;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic             append;

	logic        res_thr;
	logic [26:0] res_wait;
	logic [31:0] res_cnt;
	logic [63:0] res_tm;
	logic        res_write;

	assign in_stall = (state_q != aftt_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aftt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			aftt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = aftt_pkg::ST_SCAN;
				end
			end
			aftt_pkg::ST_SCAN: begin
				rd_en = (idx_q < used_q);
				if (!rd_en && !rd_pend_s1) begin
					state_d = aftt_pkg::ST_EVAL;
				end
			end
			aftt_pkg::ST_EVAL: begin
				state_d = aftt_pkg::ST_DECIDE;
			end
			aftt_pkg::ST_DECIDE: begin
				if (!out_valid_q || !out_stall) begin
					finish  = 1'b1;
					state_d = aftt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = aftt_pkg::ST_IDLE;
			end
		endcase
	end

	// result of the command, from the looked-up record
	always_comb begin
		res_thr   = 1'b0;
		res_wait  = 27'd0;
		res_cnt   = cnt_q;
		res_tm    = tm_q;
		res_write = 1'b0;
		case (cmd_q)
			aftt_pkg::CMD_CHECK: begin
				if (to_q != 27'd0) begin
					if (gt_q && (diff_q < {37'd0, to_q})) begin
						res_thr  = 1'b1;
						res_wait = to_q - diff_q[26:0];
					end else if (!gt_q) begin
						// clock went back: restamp and wait the full timeout
						res_thr   = 1'b1;
						res_wait  = to_q;
						res_tm    = ts_q;
						res_write = 1'b1;
					end
				end
			end
			aftt_pkg::CMD_FAIL: begin
				res_cnt   = (cnt_q != 32'hFFFF_FFFF) ? cnt_q + 32'd1 : cnt_q;
				res_tm    = ts_q;
				res_write = 1'b1;
			end
			aftt_pkg::CMD_CLEAR: begin
				res_cnt   = 32'd0;
				res_tm    = 64'd0;
				res_write = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign append = !found_q && (used_q < CW'(TABLE_DEPTH));
	assign wr_en  = finish && res_write;

	always_comb begin
		if (found_q) begin
			wr_addr = match_q;
		end else if (append) begin
			wr_addr = used_q[AW-1:0];
		end else begin
			wr_addr = old_idx_q;
		end
	end

	assign wr_data.user     = uid_q;
	assign wr_data.failures = res_cnt;
	assign wr_data.stamp    = res_tm;

	aftt_ram #(
		.WIDTH ($bits(aftt_pkg::entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= rd_en;
			if (wr_en && append) begin
				used_q <= used_q + CW'(1);
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
		if (accept) begin
			cmd_q     <= cmd;
			uid_q     <= user_id;
			ts_q      <= timestamp;
			idx_q     <= '0;
			found_q   <= 1'b0;
			match_q   <= '0;
			cnt_q     <= 32'd0;
			tm_q      <= 64'd0;
			old_tm_q  <= '1;
			old_idx_q <= '0;
		end else begin
			if (rd_en) begin
				idx_q <= idx_q + CW'(1);
			end
			if (rd_pend_s1) begin
				// first match wins; the oldest time takes the last of equals
				if (!found_q && rd_data.user == uid_q) begin
					found_q <= 1'b1;
					match_q <= rd_idx_s1;
					cnt_q   <= rd_data.failures;
					tm_q    <= rd_data.stamp;
				end
				if (rd_data.stamp <= old_tm_q) begin
					old_tm_q  <= rd_data.stamp;
					old_idx_q <= rd_idx_s1;
				end
			end
		end
		if (state_q == aftt_pkg::ST_EVAL) begin
			to_q   <= aftt_pkg::retry_timeout(cnt_q);
			gt_q   <= (ts_q > tm_q);
			diff_q <= ts_q - tm_q;
		end
		if (finish) begin
			thr_q     <= res_thr;
			wait_q    <= res_wait;
			cnt_out_q <= res_cnt;
			tm_out_q  <= res_tm;
		end
	end

	assign out_valid     = out_valid_q;
	assign throttled     = thr_q;
	assign wait_ms       = wait_q;
	assign failure_count = cnt_out_q;
	assign last_time     = tm_out_q;

endmodule

[sim/tb_auth_failure_throttle_table.sv]
`timescale 1ns / 1ps

module tb_auth_failure_throttle_table;

	localparam int unsigned TBL_DEPTH      = aftt_pkg::TABLE_DEPTH_DEFAULT;
	localparam logic [1:0]  CMD_UNUSED     = 2'd3;
	localparam int unsigned N_ITEMS        = 2000;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = TBL_DEPTH + 10;

	typedef struct {
		bit          drain;
		int unsigned phase;
		logic [1:0]  op;
		logic [63:0] uid;
		logic [63:0] ts;
	} command_t;

	typedef struct {
		logic        thr;
		logic [26:0] wait_ms;
		logic [31:0] count;
		logic [63:0] stamp;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = aftt_pkg::CMD_CHECK;
	logic [63:0] user_id = '0;
	logic [63:0] timestamp = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        throttled;
	logic [26:0] wait_ms;
	logic [31:0] failure_count;
	logic [63:0] last_time;

	command_t    cmd_backlog[$];
	verdict_t    pending_verdicts[$];
	int unsigned send_idle_pct[3] = '{34, 81, 0};
	int unsigned recv_idle_pct[3] = '{81, 34, 0};
	int unsigned recv_pct = 81;
	int unsigned n_queued = 0;
	int unsigned last_phase = 0;
	int unsigned err_count = 0;
	int unsigned idle_cycles = 0;
	logic        in_xfer = 1'b0;

	// local copy of the failure table
	logic [63:0] rec_user[TBL_DEPTH];
	logic [31:0] rec_fails[TBL_DEPTH];
	logic [63:0] rec_stamp[TBL_DEPTH];
	int unsigned rec_used = 0;

	auth_failure_throttle_table u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.user_id       (user_id),
		.timestamp     (timestamp),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.throttled     (throttled),
		.wait_ms       (wait_ms),
		.failure_count (failure_count),
		.last_time     (last_time)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [26:0] backoff_ms(logic [31:0] c);
		if (c == 32'd0) begin
			return 27'd0;
		end
		if (c <= 32'd10) begin
			return (c % 32'd5 == 32'd0) ? aftt_pkg::TIMEOUT_BASE_MS : 27'd0;
		end
		if (c < 32'd30) begin
			return aftt_pkg::TIMEOUT_BASE_MS;
		end
		if (c < 32'd140) begin
			return aftt_pkg::TIMEOUT_BASE_MS << ((c - 32'd30) / 32'd10);
		end
		return aftt_pkg::DAY_MS;
	endfunction

	function automatic void find_record(input logic [63:0] uid, output logic [31:0] cnt,
			output logic [63:0] tm);
		cnt = '0;
		tm = '0;
		for (int unsigned k = 0; k < rec_used; k++) begin
			if (rec_user[k] == uid) begin
				cnt = rec_fails[k];
				tm = rec_stamp[k];
				return;
			end
		end
	endfunction

	// update in place, append, or evict the oldest entry (last one wins a tie)
	function automatic void save_record(logic [63:0] uid, logic [31:0] cnt, logic [63:0] tm);
		int unsigned k;
		int unsigned oldest;
		logic [63:0] oldest_tm;
		bit          hit;
		oldest = 0;
		oldest_tm = '1;
		hit = 1'b0;
		k = 0;
		while (k < rec_used && !hit) begin
			if (rec_user[k] == uid) begin
				hit = 1'b1;
			end else begin
				if (rec_stamp[k] <= oldest_tm) begin
					oldest_tm = rec_stamp[k];
					oldest = k;
				end
				k++;
			end
		end
		if (k >= TBL_DEPTH) begin
			k = oldest;
		end else if (k == rec_used) begin
			rec_used++;
		end
		rec_user[k] = uid;
		rec_fails[k] = cnt;
		rec_stamp[k] = tm;
	endfunction

	function automatic void note_command(logic [1:0] op, logic [63:0] uid, logic [63:0] ts);
		logic [31:0] cnt;
		logic [63:0] tm;
		logic [26:0] to;
		verdict_t    v;
		find_record(uid, cnt, tm);
		v.thr = 1'b0;
		v.wait_ms = '0;
		case (op)
			aftt_pkg::CMD_CHECK: begin
				to = backoff_ms(cnt);
				if (to != 27'd0) begin
					if (ts > tm && (ts - tm) < 64'(to)) begin
						v.thr = 1'b1;
						v.wait_ms = 27'(64'(to) - (ts - tm));
					end else if (ts <= tm) begin
						// clock went back: restart the window from now
						tm = ts;
						save_record(uid, cnt, tm);
						v.thr = 1'b1;
						v.wait_ms = to;
					end
				end
			end
			aftt_pkg::CMD_FAIL: begin
				if (cnt != '1) begin
					cnt++;
				end
				tm = ts;
				save_record(uid, cnt, tm);
			end
			aftt_pkg::CMD_CLEAR: begin
				cnt = '0;
				tm = '0;
				save_record(uid, cnt, tm);
			end
			default: begin
			end
		endcase
		v.count = cnt;
		v.stamp = tm;
		pending_verdicts.push_back(v);
	endfunction

	function automatic void add_cmd(logic [1:0] op, logic [63:0] uid, logic [63:0] ts);
		command_t    c;
		int unsigned ph;
		ph = (n_queued < 700) ? 0 : (n_queued < 1400) ? 1 : 2;
		if (ph != last_phase) begin
			c.drain = 1'b1;
			c.phase = ph;
			c.op = aftt_pkg::CMD_CHECK;
			c.uid = '0;
			c.ts = '0;
			cmd_backlog.push_back(c);
			last_phase = ph;
		end
		c.drain = 1'b0;
		c.phase = ph;
		c.op = op;
		c.uid = uid;
		c.ts = ts;
		cmd_backlog.push_back(c);
		n_queued++;
	endfunction

	// sender
	always @(negedge clk or negedge arst_n) begin : drive_cmds
		command_t nxt;
		bit       go;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_xfer) begin
			go = 1'b0;
			if (cmd_backlog.size() > 0 && cmd_backlog[0].drain) begin
				// hold off until every outstanding result is back
				if (pending_verdicts.size() == 0) begin
					void'(cmd_backlog.pop_front());
				end
			end else if (cmd_backlog.size() > 0 &&
					$urandom_range(0, 99) >= send_idle_pct[cmd_backlog[0].phase]) begin
				nxt = cmd_backlog.pop_front();
				cmd <= nxt.op;
				user_id <= nxt.uid;
				timestamp <= nxt.ts;
				recv_pct <= recv_idle_pct[nxt.phase];
				go = 1'b1;
			end
			in_valid <= go;
		end
	end

	// receiver
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_pct);
	end

	always @(posedge clk or negedge arst_n) begin : watch_results
		verdict_t exp_v;
		if (!arst_n) begin
			in_xfer <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_verdicts.size() == 0) begin
					$error("result transfer with no command outstanding");
					err_count++;
				end else begin
					exp_v = pending_verdicts.pop_front();
					if (throttled !== exp_v.thr) begin
						$error("throttled: expected %0d, got %0d", exp_v.thr, throttled);
						err_count++;
					end
					if (wait_ms !== exp_v.wait_ms) begin
						$error("wait_ms: expected %0d, got %0d", exp_v.wait_ms, wait_ms);
						err_count++;
					end
					if (failure_count !== exp_v.count) begin
						$error("failure_count: expected %0d, got %0d", exp_v.count,
							failure_count);
						err_count++;
					end
					if (last_time !== exp_v.stamp) begin
						$error("last_time: expected %0h, got %0h", exp_v.stamp, last_time);
						err_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				note_command(cmd, user_id, timestamp);
			end
			in_xfer <= in_valid && !in_stall;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [63:0] user_a;
		logic [63:0] hot_user;
		logic [63:0] pool[40];
		logic [63:0] now;
		logic [63:0] uid;
		logic [63:0] ts;
		int unsigned r;

		user_a = 64'h0123_4567_89ab_cdef;

		// absent users and the extremes of id and time
		add_cmd(aftt_pkg::CMD_CHECK, 64'd0, 64'd0);
		add_cmd(aftt_pkg::CMD_FAIL, 64'd0, 64'd0);
		add_cmd(aftt_pkg::CMD_CHECK, '1, '1);
		add_cmd(aftt_pkg::CMD_FAIL, '1, '1);
		// counts below five carry no timeout
		repeat (4) add_cmd(aftt_pkg::CMD_FAIL, user_a, 64'd1000);
		add_cmd(aftt_pkg::CMD_CHECK, user_a, 64'd1500);
		// fifth failure: inside the window, exactly at its end, then clock going back
		add_cmd(aftt_pkg::CMD_FAIL, user_a, 64'd2000);
		add_cmd(aftt_pkg::CMD_CHECK, user_a, 64'd12000);
		add_cmd(aftt_pkg::CMD_CHECK, user_a, 64'd32000);
		add_cmd(aftt_pkg::CMD_CHECK, user_a, 64'd1000);
		add_cmd(aftt_pkg::CMD_CHECK, user_a, 64'd1000);
		add_cmd(aftt_pkg::CMD_FAIL, '1, '1);
		add_cmd(aftt_pkg::CMD_CHECK, '1, '1);
		add_cmd(aftt_pkg::CMD_CLEAR, user_a, 64'd5000);
		add_cmd(aftt_pkg::CMD_CHECK, user_a, 64'd5);
		add_cmd(CMD_UNUSED, 64'd0, 64'd77);
		add_cmd(CMD_UNUSED, 64'hdead_beef_0000_0001, '1);
		add_cmd(aftt_pkg::CMD_FAIL, 64'd0, 64'h8000_0000_0000_0000);
		add_cmd(aftt_pkg::CMD_CHECK, 64'd0, 64'd0);
		add_cmd(aftt_pkg::CMD_CLEAR, '1, 64'd0);

		hot_user = {$urandom, $urandom};
		for (int i = 0; i < 40; i++) begin
			pool[i] = {$urandom, $urandom};
		end
		now = 64'd100000;

		while (n_queued < N_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				// noise: any code, random key, random or nearby time
				ts = $urandom_range(0, 1) ? {$urandom, $urandom} : now;
				add_cmd(2'($urandom_range(0, 3)), {$urandom, $urandom}, ts);
			end else begin
				r = $urandom_range(0, 99);
				uid = (r < 30) ? hot_user : (r < 90) ? pool[$urandom_range(0, 39)] :
					{$urandom, $urandom};
				if (uid != hot_user && $urandom_range(0, 99) < 8) begin
					add_cmd(aftt_pkg::CMD_CLEAR, uid, now);
				end else begin
					repeat ($urandom_range(0, 12)) begin
						now += $urandom_range(0, 3000);
						add_cmd(aftt_pkg::CMD_FAIL, uid, now);
					end
					repeat ($urandom_range(1, 3)) begin
						case ($urandom_range(0, 4))
							0: ts = now;
							1: ts = now + $urandom_range(0, 70000);
							2: ts = now + $urandom_range(0, 134217727);
							3: ts = now - $urandom_range(0, 5000);
							default: ts = now + $urandom_range(1, 30000);
						endcase
						add_cmd(aftt_pkg::CMD_CHECK, uid, ts);
					end
				end
				now += $urandom_range(0, 20000);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || in_valid || pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
